// File: hw/rtl/spq_pkg.sv
// Shared types and codes for the stable sorted priority queue.
package spq_pkg;

	localparam int ValueW  = 32;
	localparam int PrioW   = 16;
	localparam int StatusW = 2;
	localparam int OccW    = 5;

	// Operation codes carried by the request opcode field.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	// Status codes returned with every result.
	localparam logic [StatusW-1:0] ST_OK        = 2'd0;
	localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd2;

	// Contents of one storage cell as seen by its neighbors.
	typedef struct packed {
		logic                     valid;
		logic signed [ValueW-1:0] value;
		logic signed [PrioW-1:0]  prio;
	} entry_t;

	// Broadcast command that every cell sees in the same cycle.
	typedef struct packed {
		logic                     ins;
		logic                     pop;
		logic signed [ValueW-1:0] value;
		logic signed [PrioW-1:0]  prio;
	} cmd_t;

endpackage

// File: hw/rtl/spq_if.sv
// Request and result channel interfaces of the stable sorted priority queue.
interface spq_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] item_value;
	logic signed [15:0] item_priority;

	modport source (output valid, opcode, item_value, item_priority, input ready);
	modport sink (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_value;
	logic signed [15:0] out_priority;
	logic [1:0]         status;
	logic [4:0]         occupancy;

	modport source (output valid, out_value, out_priority, status, occupancy, input ready);
	modport sink (input valid, out_value, out_priority, status, occupancy, output ready);
endinterface

// File: hw/rtl/spq_cell.sv
// One cell of the sorted array: holds one entry and trades with its neighbors.
module spq_cell
	import spq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  entry_t left_ent,
	input  logic   left_le,
	input  entry_t right_ent,
	output entry_t own_ent,
	output logic   own_le
);

	logic                     valid_q;
	logic signed [ValueW-1:0] value_q;
	logic signed [PrioW-1:0]  prio_q;
	entry_t                   next_ent;
	logic                     load;

	// This cell sorts at or before the new entry when it holds a priority not above it.
	assign own_le  = valid_q && (prio_q <= cmd.prio);
	assign own_ent = '{valid: valid_q, value: value_q, prio: prio_q};

	// On insert, cells past the slot shift right and the first one past it takes
	// the new entry; on pop, every cell takes its right neighbor.
	always_comb begin
		next_ent = own_ent;
		load     = 1'b0;
		if (cmd.ins) begin
			if (!own_le) begin
				load = 1'b1;
				if (left_le) begin
					next_ent = '{valid: 1'b1, value: cmd.value, prio: cmd.prio};
				end else begin
					next_ent = left_ent;
				end
			end
		end else if (cmd.pop) begin
			load     = 1'b1;
			next_ent = right_ent;
		end
	end

	// Valid bit is control state and is cleared on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= next_ent.valid;
		end
	end

	// Entry payload needs no reset; it is only read behind its valid bit.
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= next_ent.value;
			prio_q  <= next_ent.prio;
		end
	end

endmodule

// File: hw/rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built as a row of cells.
//
//   channel  role    payload
//   req      sink    opcode, item_value, item_priority
//   rsp      source  out_value, out_priority, status, occupancy
//
// Every request is finished in the cycle it is accepted; its result shows on rsp
// in the next cycle. One request per cycle is sustained, since all cells compare
// against the new priority at once and all shift by one place together.
// The result register frees as it is taken, so req stalls only while an earlier
// result waits on rsp. Reset clears the valid bits of all cells and the count.
module stable_sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input logic         clk,
	input logic         arst_n,
	spq_req_if.sink     req,
	spq_rsp_if.source   rsp
);

	localparam int CntW = $clog2(CAPACITY + 1);

	logic [CntW-1:0] count_q;
	logic            fire;
	logic            full;
	logic            empty;
	cmd_t            cmd;

	entry_t cell_ent [CAPACITY];
	logic   cell_le  [CAPACITY];
	entry_t left_ent [CAPACITY];
	logic   left_le  [CAPACITY];
	entry_t right_ent[CAPACITY];

	logic                     rsp_valid_q;
	logic signed [ValueW-1:0] rsp_value_q;
	logic signed [PrioW-1:0]  rsp_prio_q;
	logic [StatusW-1:0]       rsp_status_q;
	logic [OccW-1:0]          rsp_occ_q;

	// Accept a request whenever the result register is free or being emptied.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = (count_q == CntW'(CAPACITY));
	assign empty     = (count_q == '0);

	// Command broadcast to every cell.
	assign cmd.ins   = fire && (req.opcode == OP_INSERT) && !full;
	assign cmd.pop   = fire && (req.opcode == OP_POP) && !empty;
	assign cmd.value = req.item_value;
	assign cmd.prio  = req.item_priority;

	// Neighbor wiring of the row; the ends see a head that always sorts first
	// and an empty tail.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_ent[i] = '0;
			assign left_le[i]  = 1'b1;
		end else begin : g_mid
			assign left_ent[i] = cell_ent[i-1];
			assign left_le[i]  = cell_le[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_ent[i] = '0;
		end else begin : g_body
			assign right_ent[i] = cell_ent[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.left_ent (left_ent[i]),
			.left_le  (left_le[i]),
			.right_ent(right_ent[i]),
			.own_ent  (cell_ent[i]),
			.own_le   (cell_le[i])
		);
	end

	// Entry count follows the successful inserts and pops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CntW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CntW'(1);
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload: the head entry on a pop, zeros with a status otherwise.
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_value_q  <= '0;
			rsp_prio_q   <= '0;
			rsp_status_q <= ST_OK;
			if (cmd.pop) begin
				rsp_value_q <= cell_ent[0].value;
				rsp_prio_q  <= cell_ent[0].prio;
				rsp_occ_q   <= OccW'(count_q - CntW'(1));
			end else if (cmd.ins) begin
				rsp_occ_q   <= OccW'(count_q + CntW'(1));
			end else begin
				rsp_occ_q   <= OccW'(count_q);
				rsp_status_q <= (req.opcode == OP_POP) ? ST_UNDERFLOW : ST_OVERFLOW;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_value    = rsp_value_q;
	assign rsp.out_priority = rsp_prio_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.occupancy    = rsp_occ_q;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the stable sorted priority queue.
module testbench;
	import spq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_COUNT = 1500;
	localparam int PRINT_LIMIT  = 30;

	// One stored entry of the shadow queue.
	typedef struct {
		int      value;
		shortint prio;
	} held_entry_t;

	// One result as it appears on the result channel.
	typedef struct packed {
		logic signed [ValueW-1:0] value;
		logic signed [PrioW-1:0]  prio;
		logic [StatusW-1:0]       status;
		logic [OccW-1:0]          occupancy;
	} queue_result_t;

	// Shadow copy of the sorted queue and the results it has promised.
	class sorted_queue_shadow;
		held_entry_t   held[$];
		queue_result_t awaited[$];
		int            errors;

		task report(input string msg);
			if (errors < PRINT_LIMIT)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Apply one accepted request to the shadow queue and store its result.
		function void note_request(input logic op, input int v, input shortint p);
			queue_result_t r;
			held_entry_t   e;
			int            pos;
			r = '0;
			if (op == OP_INSERT) begin
				if (held.size() >= DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					// Equal priorities go behind the ones already stored.
					pos = 0;
					while (pos < held.size() && held[pos].prio <= p)
						pos++;
					e.value = v;
					e.prio  = p;
					held.insert(pos, e);
					r.status = ST_OK;
				end
			end else begin
				if (held.size() == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					e = held.pop_front();
					r.value  = e.value;
					r.prio   = e.prio;
					r.status = ST_OK;
				end
			end
			r.occupancy = OccW'(held.size());
			awaited.push_back(r);
		endfunction

		// Compare one accepted result with the oldest promised one.
		task check_result(input queue_result_t got);
			queue_result_t want;
			if (awaited.size() == 0) begin
				report("result arrived with nothing expected");
			end else begin
				want = awaited.pop_front();
				if (got.value !== want.value)
					report($sformatf("out_value %h, expected %h", got.value, want.value));
				if (got.prio !== want.prio)
					report($sformatf("out_priority %h, expected %h", got.prio, want.prio));
				if (got.status !== want.status)
					report($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.occupancy !== want.occupancy)
					report($sformatf("occupancy %0d, expected %0d",
						got.occupancy, want.occupancy));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_queue_shadow shadow = new();

	stable_sorted_priority_queue #(
		.CAPACITY(DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit well beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Offer one request after an optional idle gap and wait until it is taken.
	task automatic send_request(input logic op, input int v, input shortint p,
		input int idle);
		if (idle > 0) begin
			req_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.opcode        <= op;
		req_ch.item_value    <= v;
		req_ch.item_priority <= p;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		shadow.note_request(op, v, p);
	endtask

	// Priorities drawn so that ties, extremes and wide spreads all occur.
	function automatic shortint pick_priority();
		case ($urandom_range(0, 4))
			0: return shortint'($urandom_range(0, 3));
			1: return shortint'($urandom_range(0, 15)) - 16'sd8;
			2: begin
				case ($urandom_range(0, 3))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			default: return shortint'($urandom);
		endcase
	endfunction

	// Result receiver: random stall patterns plus long hold-offs.
	initial begin
		int   cycle;
		int   hold_left;
		int   mode;
		int   mode_left;
		logic take;
		cycle     = 0;
		hold_left = 0;
		mode      = 0;
		mode_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle == 700 || cycle == 5000)
				hold_left = 250;
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(30, 300);
				end
				mode_left--;
				case (mode)
					0: take = 1'b1;
					1: take = ($urandom_range(0, 1) == 1);
					2: take = ($urandom_range(0, 3) == 0);
					default: take = (cycle % 3 == 0);
				endcase
			end
			rsp_ch.ready <= take;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		queue_result_t got;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.value     = rsp_ch.out_value;
			got.prio      = rsp_ch.out_priority;
			got.status    = rsp_ch.status;
			got.occupancy = rsp_ch.occupancy;
			shadow.check_result(got);
		end
	end

	// Reset, directed requests, random requests and the final verdict.
	initial begin
		int      sent;
		int      burst;
		int      gap;
		int      pop_pct;
		int      mode_left;
		logic    op;
		int      k;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.opcode        <= OP_INSERT;
		req_ch.item_value    <= 0;
		req_ch.item_priority <= 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pop of an empty queue, with nonzero fields that must be ignored.
		send_request(OP_POP, 32'h7FFFFFFF, 16'sh7FFF, 0);
		// Fill the queue with extreme values, extreme priorities and ties.
		send_request(OP_INSERT, 32'h80000000, 16'sd0, 0);
		send_request(OP_INSERT, 32'h7FFFFFFF, 16'sd0, 1);
		send_request(OP_INSERT, 1, -16'sd32768, 0);
		send_request(OP_INSERT, -1, 16'sd32767, 0);
		send_request(OP_INSERT, 0, -16'sd1, 2);
		send_request(OP_INSERT, 5, 16'sd0, 0);
		send_request(OP_INSERT, 6, 16'sd32767, 0);
		send_request(OP_INSERT, 7, -16'sd32768, 1);
		send_request(OP_INSERT, 32'h55555555, 16'sh5555, 0);
		send_request(OP_INSERT, 32'hAAAAAAAA, 16'shAAAA, 0);
		for (k = 11; k <= 16; k++)
			send_request(OP_INSERT, k, shortint'(k % 3) - 16'sd1, 0);
		// Insert into a full queue must be rejected.
		send_request(OP_INSERT, 99, -16'sd32768, 0);
		for (k = 0; k < 4; k++)
			send_request(OP_POP, $urandom, shortint'($urandom), k % 2);

		// Random traffic in bursts; the insert share swings so the queue fills and drains.
		sent      = 0;
		mode_left = 0;
		pop_pct   = 50;
		while (sent < RANDOM_COUNT) begin
			if (mode_left <= 0) begin
				case ($urandom_range(0, 2))
					0: pop_pct = 15;
					1: pop_pct = 50;
					default: pop_pct = 85;
				endcase
				mode_left = $urandom_range(20, 60);
			end
			burst = $urandom_range(1, 24);
			gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			for (k = 0; k < burst; k++) begin
				op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT;
				send_request(op, $urandom, pick_priority(), (k == 0) ? gap : 0);
				sent++;
				mode_left--;
			end
		end
		req_ch.valid <= 1'b0;

		// Drain all outstanding results, then watch for stray ones.
		while (shadow.awaited.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (shadow.errors == 0 && shadow.awaited.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: stable_sorted_priority_queue.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_sorted_priority_queue.sv
bench/testbench.sv
